>>> hdl/sha256_pkg.sv
package sha256_pkg;

    typedef struct packed {
        logic [31:0] message_word;
        logic [2:0]  valid_bytes;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    typedef struct packed {
        logic        load_word;
        logic [31:0] word;
        logic        start_block;
        logic        round_step;
        logic        finish_block;
        logic        reset_chain;
        logic [2:0]  out_index;
    } dp_cmd_t;

    typedef struct packed {
        logic [4:0]  fill;
        logic [31:0] out_word;
        logic [63:0] bit_count;
    } dp_status_t;

    localparam int BLOCK_WORDS = 16;
    localparam logic [31:0] PAD_WORD = 32'h8000_0000;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

>>> hdl/sha256_datapath.sv
module sha256_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sha256_pkg::dp_cmd_t    cmd,
    input  logic [5:0]             bits_add,
    input  logic                   count_add,
    output sha256_pkg::dp_status_t status
);

    logic [31:0] chain_reg [8];
    logic [31:0] vars_reg [8];
    logic [31:0] win_reg [16];
    logic [63:0] count_reg;
    logic [4:0]  fill_reg;
    logic [5:0]  round_reg;

    logic [31:0] w, w2, w15, s0w, s1w, s1, ch, t1, s0, maj, t2;
    logic [3:0]  rix;

    always_comb
    begin
        rix = round_reg[3:0];
        w2  = win_reg[rix - 4'd2];
        w15 = win_reg[rix - 4'd15];
        s0w = sha256_pkg::rotr(w15, 7) ^ sha256_pkg::rotr(w15, 18) ^ (w15 >> 3);
        s1w = sha256_pkg::rotr(w2, 17) ^ sha256_pkg::rotr(w2, 19) ^ (w2 >> 10);
        if (round_reg < 6'd16)
            w = win_reg[rix];
        else
            w = s1w + win_reg[rix - 4'd7] + s0w + win_reg[rix];
        s1 = sha256_pkg::rotr(vars_reg[4], 6) ^ sha256_pkg::rotr(vars_reg[4], 11)
           ^ sha256_pkg::rotr(vars_reg[4], 25);
        ch = (vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]);
        t1 = vars_reg[7] + s1 + ch + sha256_pkg::ROUND_K[round_reg] + w;
        s0 = sha256_pkg::rotr(vars_reg[0], 2) ^ sha256_pkg::rotr(vars_reg[0], 13)
           ^ sha256_pkg::rotr(vars_reg[0], 22);
        maj = (vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
            ^ (vars_reg[1] & vars_reg[2]);
        t2 = s0 + maj;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= sha256_pkg::INIT_H[i];
            count_reg <= '0;
            fill_reg  <= '0;
            round_reg <= '0;
        end
        else
        begin
            if (count_add)
                count_reg <= count_reg + {58'd0, bits_add};
            if (cmd.load_word)
                fill_reg <= fill_reg + 5'd1;
            if (cmd.start_block)
            begin
                round_reg <= '0;
                fill_reg  <= '0;
            end
            if (cmd.round_step)
                round_reg <= round_reg + 6'd1;
            if (cmd.finish_block)
                for (int i = 0; i < 8; i++)
                    chain_reg[i] <= chain_reg[i] + vars_reg[i];
            if (cmd.reset_chain)
            begin
                for (int i = 0; i < 8; i++)
                    chain_reg[i] <= sha256_pkg::INIT_H[i];
                count_reg <= '0;
                fill_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_word)
            win_reg[fill_reg[3:0]] <= cmd.word;
        if (cmd.start_block)
            for (int i = 0; i < 8; i++)
                vars_reg[i] <= chain_reg[i];
        if (cmd.round_step)
        begin
            win_reg[rix] <= w;
            vars_reg[7] <= vars_reg[6];
            vars_reg[6] <= vars_reg[5];
            vars_reg[5] <= vars_reg[4];
            vars_reg[4] <= vars_reg[3] + t1;
            vars_reg[3] <= vars_reg[2];
            vars_reg[2] <= vars_reg[1];
            vars_reg[1] <= vars_reg[0];
            vars_reg[0] <= t1 + t2;
        end
    end

    assign status.fill      = fill_reg;
    assign status.out_word  = chain_reg[cmd.out_index];
    assign status.bit_count = count_reg;

endmodule

>>> hdl/sha256_control.sv
module sha256_control (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  sha256_pkg::in_item_t   in_item,
    output logic                   out_valid,
    input  logic                   out_stall,
    output sha256_pkg::out_item_t  out_item,
    output sha256_pkg::dp_cmd_t    cmd,
    output logic [5:0]             bits_add,
    output logic                   count_add,
    input  sha256_pkg::dp_status_t status
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FIN   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_PAD   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    localparam logic [2:0] PH_WORD = 3'd0;
    localparam logic [2:0] PH_MARK = 3'd1;
    localparam logic [2:0] PH_ZERO = 3'd2;
    localparam logic [2:0] PH_LO   = 3'd3;
    localparam logic [2:0] PH_DONE = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  round_reg, round_next;
    logic        pad_reg, pad_next;
    logic [2:0]  phase_reg, phase_next;
    logic [31:0] hold_reg, hold_next;
    logic        full_reg, full_next;
    logic [2:0]  idx_reg, idx_next;
    logic        ov_reg, ov_next;
    sha256_pkg::out_item_t oi_reg, oi_next;
    logic        take;
    logic [2:0]  nb;
    logic [31:0] keep, padded;

    assign in_stall  = (state_reg != ST_IDLE);
    assign take      = in_valid && !in_stall;
    assign out_valid = ov_reg;
    assign out_item  = oi_reg;

    always_comb
    begin
        nb = (in_item.valid_bytes > 3'd4) ? 3'd4 : in_item.valid_bytes;
        keep = 32'hffff_ffff << (6'd8 * (6'd4 - {3'd0, nb}));
        if (nb == 3'd0)
            keep = '0;
        padded = (in_item.message_word & keep) | (32'h80 << (6'd8 * (6'd3 - {3'd0, nb})));
    end

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        pad_next   = pad_reg;
        phase_next = phase_reg;
        hold_next  = hold_reg;
        full_next  = full_reg;
        idx_next   = idx_reg;
        ov_next    = ov_reg;
        oi_next    = oi_reg;
        cmd        = '0;
        cmd.out_index = idx_reg;
        bits_add   = 6'd32;
        count_add  = 1'b0;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    count_add = 1'b1;
                    if (!in_item.last)
                    begin
                        cmd.load_word = 1'b1;
                        cmd.word = in_item.message_word;
                        if (status.fill == 5'd15)
                            state_next = ST_FIN;
                    end
                    else
                    begin
                        bits_add   = {nb, 3'd0};
                        pad_next   = 1'b1;
                        state_next = ST_PAD;
                        phase_next = PH_WORD;
                        full_next  = (nb == 3'd4);
                        if (nb == 3'd4)
                            hold_next = in_item.message_word;
                        else if (nb == 3'd0)
                            hold_next = sha256_pkg::PAD_WORD;
                        else
                            hold_next = padded;
                    end
                end
            end
            ST_FIN:
            begin
                cmd.start_block = 1'b1;
                round_next = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round_step = 1'b1;
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.finish_block = 1'b1;
                idx_next = '0;
                if (!pad_reg)
                    state_next = ST_IDLE;
                else if (phase_reg == PH_DONE)
                    state_next = ST_OUT;
                else
                    state_next = ST_PAD;
            end
            ST_PAD:
            begin
                cmd.load_word = 1'b1;
                case (phase_reg)
                    PH_WORD:
                    begin
                        cmd.word = hold_reg;
                        phase_next = full_reg ? PH_MARK : PH_ZERO;
                    end
                    PH_MARK:
                    begin
                        cmd.word = sha256_pkg::PAD_WORD;
                        phase_next = PH_ZERO;
                    end
                    PH_ZERO:
                    begin
                        if (status.fill == 5'd14)
                        begin
                            cmd.word = status.bit_count[63:32];
                            phase_next = PH_LO;
                        end
                        else
                            cmd.word = '0;
                    end
                    PH_LO:
                    begin
                        cmd.word = status.bit_count[31:0];
                        phase_next = PH_DONE;
                    end
                    default: cmd.word = '0;
                endcase
                if (status.fill == 5'd15)
                    state_next = ST_FIN;
            end
            ST_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    oi_next.digest_word = status.out_word;
                    oi_next.word_index = idx_reg;
                    oi_next.last_word = (idx_reg == 3'd7);
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        cmd.reset_chain = 1'b1;
                        pad_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
            pad_reg   <= 1'b0;
            phase_reg <= PH_WORD;
            full_reg  <= 1'b0;
            idx_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            pad_reg   <= pad_next;
            phase_reg <= phase_next;
            full_reg  <= full_next;
            idx_reg   <= idx_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        oi_reg   <= oi_next;
    end

endmodule

>>> hdl/sha256_hash_engine.sv
// SHA-256 engine.
// Input channel (in_valid/in_stall, in_item): message as big-endian 32-bit
// words; last marks the final word, which carries 0..4 valid bytes.
// Output channel (out_valid/out_stall, out_item): eight digest words, index
// 0 to 7, after each last item; last_word marks index 7.
// A non-last word leaves the engine ready for the next word, but the
// 16th word of a block is followed by stalls for the block start, 64
// rounds on a single round unit and the chaining add. On a last item
// the padding words are loaded one a cycle, one or two blocks are
// compressed, then the digest words follow one a cycle unless stalled.
// in_stall is high whenever the controller is busy.
// A stall on the output holds the current item and pauses the digest
// sequence. Reset clears the length, fill and chaining value to the
// standard initial hash; the message window is not cleared.
module sha256_hash_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  sha256_pkg::in_item_t  in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output sha256_pkg::out_item_t out_item
);

    sha256_pkg::dp_cmd_t    cmd;
    sha256_pkg::dp_status_t status;
    logic [5:0]             bits_add;
    logic                   count_add;

    sha256_control u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cmd       (cmd),
        .bits_add  (bits_add),
        .count_add (count_add),
        .status    (status)
    );

    sha256_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .bits_add  (bits_add),
        .count_add (count_add),
        .status    (status)
    );

endmodule

>>> bench/sha256_hash_checker.sv
module sha256_hash_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  sha256_pkg::in_item_t  in_item,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  sha256_pkg::out_item_t out_item,
    output int                    fail_count,
    output int                    pending_count
);

    logic [31:0] chain [8];
    logic [31:0] msg_block [16];
    logic [63:0] length_bits;
    int          fill;
    sha256_pkg::out_item_t digest_q [$];

    function automatic logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] v [8];
        logic [31:0] w [64];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int t = 0; t < 64; t++)
        begin
            if (t < 16)
                w[t] = msg_block[t];
            else
                w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                     + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
        end
        for (int i = 0; i < 8; i++)
            v[i] = chain[i];
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::ROUND_K[t] + w[t];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int i = 7; i > 0; i--)
                v[i] = v[i-1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain[i] = chain[i] + v[i];
    endtask

    task automatic append_word(logic [31:0] w);
        msg_block[fill] = w;
        fill++;
        if (fill == sha256_pkg::BLOCK_WORDS)
        begin
            compress();
            fill = 0;
        end
    endtask

    task automatic absorb(sha256_pkg::in_item_t it);
        int                    nb;
        sha256_pkg::out_item_t d;
        nb = it.valid_bytes;
        if (!it.last || nb > 4)
            nb = 4;
        if (!it.last)
        begin
            length_bits += 64'd32;
            append_word(it.message_word);
            return;
        end
        length_bits += 64'(nb * 8);
        if (nb == 4)
        begin
            append_word(it.message_word);
            append_word(sha256_pkg::PAD_WORD);
        end
        else if (nb == 0)
            append_word(sha256_pkg::PAD_WORD);
        else
            append_word((it.message_word & (32'hffffffff << (8 * (4 - nb))))
                        | (32'h80 << (8 * (3 - nb))));
        while (fill != sha256_pkg::BLOCK_WORDS - 2)
            append_word(32'h0);
        append_word(length_bits[63:32]);
        append_word(length_bits[31:0]);
        for (int i = 0; i < 8; i++)
        begin
            d.digest_word = chain[i];
            d.word_index  = 3'(i);
            d.last_word   = (i == 7);
            digest_q.push_back(d);
        end
        for (int i = 0; i < 8; i++)
            chain[i] = sha256_pkg::INIT_H[i];
        length_bits = '0;
        fill = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                chain[i] = sha256_pkg::INIT_H[i];
            length_bits = '0;
            fill = 0;
            fail_count = 0;
            digest_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (digest_q.size() == 0)
                begin
                    $display("%0t: unexpected digest item, expected none actual %h",
                             $realtime, out_item);
                    fail_count++;
                end
                else if (out_item !== digest_q[0])
                begin
                    $display("%0t: digest mismatch, expected %h_%0d_%0d actual %h_%0d_%0d",
                             $realtime, digest_q[0].digest_word, digest_q[0].word_index,
                             digest_q[0].last_word, out_item.digest_word,
                             out_item.word_index, out_item.last_word);
                    fail_count++;
                    void'(digest_q.pop_front());
                end
                else
                    void'(digest_q.pop_front());
            end
            if (in_valid && !in_stall)
                absorb(in_item);
        end
        pending_count = digest_q.size();
    end

endmodule

>>> bench/sha256_hash_engine_tb.sv
module sha256_hash_engine_tb;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    sha256_pkg::in_item_t  in_item = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    sha256_pkg::out_item_t out_item;
    int                    fail_count;
    int                    pending_count;
    int                    cycle_count = 0;
    bit                    quiet_tail = 1'b0;
    bit                    hold_req = 1'b0;
    bit                    hold_done = 1'b0;
    int                    hold_len = 0;

    always #5 clk = ~clk;

    sha256_hash_engine i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item (out_item)
    );

    sha256_hash_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_item      (in_item),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_item     (out_item),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // receiver: random stall bursts, or one long hold-off on request
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            out_stall <= 1'b1;
            if (hold_len < 300)
                hold_len <= hold_len + 1;
            else
                hold_done <= 1'b1;
        end
        else if (quiet_tail)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 9);
        end
        else
            out_stall <= 1'b0;
    end

    task automatic send(logic [31:0] w, logic [2:0] nb, logic lst);
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{message_word: w, valid_bytes: nb, last: lst};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    // message of n full words plus a last word
    task automatic send_message(int n);
        logic [2:0] nb;
        for (int i = 0; i < n; i++)
            send(rand_word(), ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd4,
                 1'b0);
        nb = 3'($urandom_range(0, 7));
        send(rand_word(), nb, 1'b1);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every last-word byte count, block-edge lengths
        for (int nb = 0; nb < 8; nb++)
            send(32'hffffffff, 3'(nb), 1'b1);
        send(32'h61626300, 3'd3, 1'b1);
        for (int i = 0; i < 13; i++)
            send(32'h0, 3'd4, 1'b0);
        send(32'habcdef01, 3'd4, 1'b1);
        for (int i = 0; i < 14; i++)
            send(32'hffffffff, 3'(i % 8), 1'b0);
        send(32'h12345678, 3'd1, 1'b1);
        drain();

        // long receiver hold-off while input keeps coming
        hold_req <= 1'b1;
        for (int m = 0; m < 4; m++)
            send_message($urandom_range(0, 3));
        drain();

        for (int m = 0; m < 34; m++)
        begin
            if (m == 26)
                quiet_tail = 1'b1;
            send_message($urandom_range(0, 17));
            if (m == 15)
                drain();
        end
        drain();
        repeat (200) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> sha256_hash_engine.f
hdl/sha256_pkg.sv
hdl/sha256_datapath.sv
hdl/sha256_control.sv
hdl/sha256_hash_engine.sv
bench/sha256_hash_checker.sv
bench/sha256_hash_engine_tb.sv
